// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; included by esrf_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/esrf_pkg.sv -----
package esrf_pkg;

	localparam int COUNT_W = 16;
	localparam int TIME_W  = 32;
	localparam int SPEED_W = 40;
	localparam int ALPHA_W = 17;
	localparam int CFG_W   = 17;
	localparam int DEN_W   = COUNT_W + TIME_W;
	localparam int PROD_W  = SPEED_W + ALPHA_W;

	// One quotient bit per divider step.
	localparam int DIV_STEPS = SPEED_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// 60000 ms per minute, times 256 for the Q32.8 result.
	localparam logic [23:0] SPEED_SCALE = 24'd15360000;
	localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [15:0] CPR_RESET   = 16'd1024;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd52429;

	typedef enum logic [0:0] {
		REG_COUNTS_PER_REV = 1'b0,
		REG_FILTER_ALPHA   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic div_step;
		logic mul;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/encoder_speed_rpm_filter.sv -----
// Channel   Handshake              Carries
// in        in_valid / in_ready    encoder_count, now_ms
// out       out_valid / out_ready  speed_rpm, smoothed_rpm
// cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// A request passes from acceptance through the load, divide, multiply and
// finish states back to ready; the result is registered in the finish state.
// The restoring divider produces one quotient bit per cycle.
// Reset restores counts_per_rev 1024, alpha 52429 and clears the history.
// A result waiting in the output register does not block the next request;
// only a second result waits for out_ready.
module encoder_speed_rpm_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [esrf_pkg::COUNT_W-1:0]        encoder_count,
	input  logic [esrf_pkg::TIME_W-1:0]         now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [esrf_pkg::SPEED_W-1:0]        speed_rpm,
	output logic [esrf_pkg::SPEED_W-1:0]        smoothed_rpm,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [esrf_pkg::CFG_W-1:0]          cfg_data
);

	esrf_pkg::dp_cmd_t    cmd;
	esrf_pkg::dp_status_t status;

	esrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	esrf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.encoder_count (encoder_count),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.speed_rpm     (speed_rpm),
		.smoothed_rpm  (smoothed_rpm)
	);

endmodule

// ----- hw/rtl/esrf_ctrl.sv -----
`include "assert_macros.svh"

module esrf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  esrf_pkg::dp_status_t  status,
	output esrf_pkg::dp_cmd_t     cmd
);

	esrf_pkg::state_t state_q, state_next;
	logic [esrf_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic div_last;

	assign div_last = (div_cnt_q == esrf_pkg::DIV_CNT_W'(esrf_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= esrf_pkg::ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			esrf_pkg::ST_IDLE: begin
				if (in_valid) state_next = esrf_pkg::ST_LOAD;
			end
			esrf_pkg::ST_LOAD: begin
				state_next = esrf_pkg::ST_DIV;
			end
			esrf_pkg::ST_DIV: begin
				if (div_last) state_next = esrf_pkg::ST_MUL;
			end
			esrf_pkg::ST_MUL: begin
				state_next = esrf_pkg::ST_FIN;
			end
			esrf_pkg::ST_FIN: begin
				// Hold the finished result until the output register is free.
				if (status.out_free) state_next = esrf_pkg::ST_IDLE;
			end
			default: begin
				state_next = esrf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			esrf_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			esrf_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
			end
			esrf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			esrf_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			esrf_pkg::ST_FIN: begin
				cmd.finish = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`ASSERT_IMPL(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0(cmd))
	`ASSERT_NEXT(a_load_then_div, clk, arst_n, cmd.load, state_q == esrf_pkg::ST_DIV && div_cnt_q == '0)
	`ASSERT_NEXT(a_div_full_length, clk, arst_n, cmd.div_step && !div_last, state_q == esrf_pkg::ST_DIV)
	`ASSERT_IMPL(a_ready_only_idle, clk, arst_n, in_ready, !cmd.div_step && !cmd.finish)

endmodule

// ----- hw/rtl/esrf_dp.sv -----
module esrf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esrf_pkg::dp_cmd_t                   cmd,
	output esrf_pkg::dp_status_t                status,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [esrf_pkg::CFG_W-1:0]          cfg_data,
	input  logic [esrf_pkg::COUNT_W-1:0]        encoder_count,
	input  logic [esrf_pkg::TIME_W-1:0]         now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [esrf_pkg::SPEED_W-1:0]        speed_rpm,
	output logic [esrf_pkg::SPEED_W-1:0]        smoothed_rpm
);

	logic [15:0]                        cpr_q;
	logic [esrf_pkg::ALPHA_W-1:0]       alpha_q;
	logic [esrf_pkg::COUNT_W-1:0]       prev_count_q;
	logic [esrf_pkg::TIME_W-1:0]        prev_time_q;
	logic [esrf_pkg::SPEED_W-1:0]       filt_q;

	logic [esrf_pkg::COUNT_W-1:0]       mag_q;
	logic [esrf_pkg::TIME_W-1:0]        elapsed_q;
	logic [esrf_pkg::DEN_W-1:0]         den_q;
	logic [esrf_pkg::DEN_W-1:0]         rem_q;
	logic [esrf_pkg::SPEED_W-1:0]       num_q;
	logic [esrf_pkg::PROD_W-1:0]        prod_old_q;
	logic [esrf_pkg::PROD_W-1:0]        prod_new_q;
	logic [esrf_pkg::SPEED_W-1:0]       speed_q;

	logic                               out_valid_q;
	logic [esrf_pkg::SPEED_W-1:0]       speed_out_q;
	logic [esrf_pkg::SPEED_W-1:0]       smooth_out_q;

	logic [esrf_pkg::COUNT_W-1:0]       diff;
	logic [esrf_pkg::COUNT_W-1:0]       mag;
	logic [esrf_pkg::DEN_W:0]           rem_shift;
	logic                               q_bit;
	logic [esrf_pkg::SPEED_W-1:0]       speed;
	logic [esrf_pkg::ALPHA_W-1:0]       alpha_sat;
	logic [esrf_pkg::PROD_W:0]          filt_sum;
	logic [esrf_pkg::SPEED_W-1:0]       filt_next;

	// Wrapped difference read as signed; the most negative value keeps magnitude 32768.
	assign diff = encoder_count - prev_count_q;
	assign mag  = diff[esrf_pkg::COUNT_W-1] ? (~diff + 1'b1) : diff;

	// Restoring division step: the remainder stays below a nonzero divisor.
	assign rem_shift = {rem_q, num_q[esrf_pkg::SPEED_W-1]};
	assign q_bit     = (rem_shift >= {1'b0, den_q});

	// A zero divisor (no elapsed time or zero counts per rev) reads as zero speed.
	assign speed = (den_q == '0) ? '0 : num_q;

	assign alpha_sat = (alpha_q > esrf_pkg::ONE_Q16) ? esrf_pkg::ONE_Q16 : alpha_q;

	assign filt_sum  = {1'b0, prod_old_q} + {1'b0, prod_new_q};
	assign filt_next = filt_sum[16 +: esrf_pkg::SPEED_W];

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q        <= esrf_pkg::CPR_RESET;
			alpha_q      <= esrf_pkg::ALPHA_RESET;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			filt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					esrf_pkg::REG_COUNTS_PER_REV: cpr_q <= cfg_data[15:0];
					esrf_pkg::REG_FILTER_ALPHA:   alpha_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				prev_count_q <= encoder_count;
				prev_time_q  <= now_ms;
			end
			if (cmd.finish) begin
				filt_q      <= filt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_q     <= mag;
			elapsed_q <= now_ms - prev_time_q;
		end
		if (cmd.load) begin
			den_q <= esrf_pkg::DEN_W'(cpr_q) * esrf_pkg::DEN_W'(elapsed_q);
			num_q <= esrf_pkg::SPEED_W'(mag_q) * esrf_pkg::SPEED_W'(esrf_pkg::SPEED_SCALE);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			if (q_bit) begin
				rem_q <= esrf_pkg::DEN_W'(rem_shift - {1'b0, den_q});
			end else begin
				rem_q <= rem_shift[esrf_pkg::DEN_W-1:0];
			end
			num_q <= {num_q[esrf_pkg::SPEED_W-2:0], q_bit};
		end
		if (cmd.mul) begin
			speed_q    <= speed;
			prod_old_q <= esrf_pkg::PROD_W'(filt_q) * esrf_pkg::PROD_W'(alpha_sat);
			prod_new_q <= esrf_pkg::PROD_W'(speed)
				* esrf_pkg::PROD_W'(esrf_pkg::ONE_Q16 - alpha_sat);
		end
		if (cmd.finish) begin
			speed_out_q  <= speed_q;
			smooth_out_q <= filt_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign speed_rpm    = speed_out_q;
	assign smoothed_rpm = smooth_out_q;

endmodule
